>>> rtl/core/lbp_pkg.sv
// Package of shared constants and types for the LSB-first bit packer.
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

    // Fixed field widths of the two channels
    localparam int LBP_VALUE_W     = 64;
    localparam int LBP_BIT_LEN_W   = 7;
    localparam int LBP_BYTE_W      = 8;
    localparam int LBP_VALID_W     = 4;
    localparam int LBP_TOTAL_W     = 32;

    // Defaults for the top-level parameters
    localparam int LBP_MAX_FIELD_BITS = 64;
    localparam int LBP_COUNT_BITS     = 32;

    // Bits in one stream byte
    localparam int LBP_BYTE_BITS = 8;

    // Depth of the queue between front and back
    localparam int LBP_Q_DEPTH = 2;

    // Queue status as seen by its producer and consumer
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } lbp_q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lbp_ifs.sv
// Valid/ready channel interfaces for input items and output bytes.
`timescale 1ns / 1ps
`default_nettype none

interface lbp_in_if;
    logic                               valid;
    logic                               ready;
    logic [lbp_pkg::LBP_VALUE_W-1:0]     value;
    logic [lbp_pkg::LBP_BIT_LEN_W-1:0]   bit_len;
    logic                               flush;

    modport source (output valid, output value, output bit_len, output flush, input ready);
    modport sink   (input valid, input value, input bit_len, input flush, output ready);
endinterface

interface lbp_out_if;
    logic                            valid;
    logic                            ready;
    logic [lbp_pkg::LBP_BYTE_W-1:0]  out_byte;
    logic [lbp_pkg::LBP_VALID_W-1:0] valid_bits;
    logic                            last_of_run;
    logic [lbp_pkg::LBP_TOTAL_W-1:0] total_bits;

    modport source (output valid, output out_byte, output valid_bits, output last_of_run,
                    output total_bits, input ready);
    modport sink   (input valid, input out_byte, input valid_bits, input last_of_run,
                    input total_bits, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lbp_front.sv
// Front stage: accepts input words, saturates the bit count and masks the value.
`timescale 1ns / 1ps
`default_nettype none

module lbp_front #(
    parameter int MAX_FIELD_BITS = lbp_pkg::LBP_MAX_FIELD_BITS,
    parameter int CW             = $clog2(MAX_FIELD_BITS + 1)
) (
    lbp_in_if.sink                   item,
    input  lbp_pkg::lbp_q_stat_t     q_stat,
    output logic                     q_push,
    output logic [MAX_FIELD_BITS-1:0] q_value,
    output logic [CW-1:0]            q_count,
    output logic                     q_flush
);
    import lbp_pkg::*;

    logic [CW-1:0]             count_sat;
    logic [MAX_FIELD_BITS-1:0] keep_mask;

    assign item.ready = q_stat.not_full;
    assign q_push     = item.valid && q_stat.not_full;

    always_comb
    begin
        if (item.bit_len > LBP_BIT_LEN_W'(MAX_FIELD_BITS))
        begin
            count_sat = CW'(MAX_FIELD_BITS);
        end
        else
        begin
            count_sat = CW'(item.bit_len);
        end
        for (int i = 0; i < MAX_FIELD_BITS; i++)
        begin
            keep_mask[i] = (CW'(i) < count_sat);
        end
    end

    assign q_value = item.value[MAX_FIELD_BITS-1:0] & keep_mask;
    assign q_count = count_sat;
    assign q_flush = item.flush;

endmodule

`default_nettype wire

>>> rtl/core/lbp_queue.sv
// Short first-in first-out queue between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module lbp_queue #(
    parameter int DATA_W = 72
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_W-1:0]    wr_data,
    input  logic                 pop,
    output logic [DATA_W-1:0]    rd_data,
    output lbp_pkg::lbp_q_stat_t stat
);
    import lbp_pkg::*;

    localparam int PTR_W = $clog2(LBP_Q_DEPTH);
    localparam int FILL_W = $clog2(LBP_Q_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [LBP_Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign stat.not_full  = (fill_reg != FILL_W'(LBP_Q_DEPTH));
    assign stat.not_empty = (fill_reg != '0);
    assign do_push = push && stat.not_full;
    assign do_pop  = pop && stat.not_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(LBP_Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(LBP_Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbp_back.sv
// Back stage: merges items into the accumulator, emits one byte per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module lbp_back #(
    parameter int MAX_FIELD_BITS = lbp_pkg::LBP_MAX_FIELD_BITS,
    parameter int COUNT_BITS     = lbp_pkg::LBP_COUNT_BITS,
    parameter int CW             = $clog2(MAX_FIELD_BITS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lbp_pkg::lbp_q_stat_t      q_stat,
    output logic                      q_pop,
    input  logic [MAX_FIELD_BITS-1:0] q_value,
    input  logic [CW-1:0]             q_count,
    input  logic                      q_flush,
    lbp_out_if.source                 stream
);
    import lbp_pkg::*;

    localparam int ACC_W = MAX_FIELD_BITS + LBP_BYTE_BITS - 1;
    localparam int ACC_CW = $clog2(ACC_W + 1);

    // Accumulator: bit 0 is the oldest unsent bit. When idle it holds the partial byte.
    logic [ACC_W-1:0]      acc_reg, acc_next, rem_acc;
    logic [ACC_CW-1:0]     cnt_reg, cnt_next, rem_cnt, after_full;
    logic [COUNT_BITS-1:0] pos_reg, pos_next, rem_pos;
    logic                  busy_reg, busy_next;
    logic                  flush_reg, flush_next;

    logic [LBP_BYTE_W-1:0]  byte_reg;
    logic [LBP_VALID_W-1:0] vbits_reg;
    logic                   last_reg;
    logic [LBP_TOTAL_W-1:0] total_reg;
    logic                   out_valid_reg, out_valid_next;

    logic        full_byte, part_byte, need, out_free, fire, last_full, free;
    logic [63:0] pos_wide;

    always_comb
    begin
        full_byte = busy_reg && (cnt_reg >= ACC_CW'(LBP_BYTE_BITS));
        part_byte = busy_reg && !full_byte && flush_reg && (cnt_reg != '0);
        need      = full_byte || part_byte;
        out_free  = !out_valid_reg || stream.ready;
        fire      = need && out_free;

        after_full = cnt_reg - ACC_CW'(LBP_BYTE_BITS);
        last_full  = (after_full < ACC_CW'(LBP_BYTE_BITS)) && !(flush_reg && (after_full != '0));

        rem_acc = acc_reg;
        rem_cnt = cnt_reg;
        rem_pos = pos_reg;
        if (fire && full_byte)
        begin
            rem_acc = acc_reg >> LBP_BYTE_BITS;
            rem_cnt = after_full;
            rem_pos = pos_reg + COUNT_BITS'(LBP_BYTE_BITS);
        end
        else if (fire && part_byte)
        begin
            rem_acc = '0;
            rem_cnt = '0;
            rem_pos = pos_reg + COUNT_BITS'(cnt_reg);
        end

        // The current item is finished once nothing is left to send for it.
        free  = !busy_reg || (need ? (fire && (part_byte || last_full)) : 1'b1);
        q_pop = free && q_stat.not_empty;

        if (q_pop)
        begin
            acc_next   = rem_acc | (ACC_W'(q_value) << rem_cnt[2:0]);
            cnt_next   = rem_cnt + ACC_CW'(q_count);
            flush_next = q_flush;
            busy_next  = 1'b1;
        end
        else
        begin
            acc_next   = rem_acc;
            cnt_next   = rem_cnt;
            flush_next = flush_reg;
            busy_next  = busy_reg && !free;
        end
        pos_next = rem_pos;

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        pos_wide = 64'(rem_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            busy_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            busy_reg      <= busy_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg  <= acc_reg[LBP_BYTE_W-1:0];
            vbits_reg <= full_byte ? LBP_VALID_W'(LBP_BYTE_BITS) : LBP_VALID_W'(cnt_reg);
            last_reg  <= full_byte ? last_full : 1'b1;
            total_reg <= pos_wide[LBP_TOTAL_W-1:0];
        end
    end

    assign stream.valid       = out_valid_reg;
    assign stream.out_byte    = byte_reg;
    assign stream.valid_bits  = vbits_reg;
    assign stream.last_of_run = last_reg;
    assign stream.total_bits  = total_reg;

endmodule

`default_nettype wire

>>> rtl/core/lsb_first_bit_packer.sv
// Top level of the LSB-first variable-length bit packer.
//
//   Channel  Dir  Handshake     Word carried
//   -------  ---  ------------  --------------------------------------------------
//   item     in   valid/ready   value[63:0], bit_len[6:0], flush
//   stream   out  valid/ready   out_byte[7:0], valid_bits[3:0], last_of_run,
//                               total_bits[31:0]
//
// The packing stage sends one byte per cycle while its output register is free, and an
// item holds it until its last full byte, or its flushed partial byte, has been sent.
// The next item is merged into the accumulator in the same cycle that the last byte of
// the previous one is sent. Reset clears the pending bits, the running bit count and
// the queue at once; there is no clearing pass. A two-word queue decouples the input
// from the packing stage. The output register holds a byte steady until it is taken;
// a new byte is formed only in a cycle in which that register is empty or being
// emptied, so the packing stage stalls for as long as the receiver does.
`timescale 1ns / 1ps
`default_nettype none

module lsb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = lbp_pkg::LBP_MAX_FIELD_BITS,
    parameter int COUNT_BITS     = lbp_pkg::LBP_COUNT_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    lbp_in_if.sink     item,
    lbp_out_if.source  stream
);
    import lbp_pkg::*;

    // Width of a saturated bit count, and of one queue entry {flush, count, value}.
    localparam int CW     = $clog2(MAX_FIELD_BITS + 1);
    localparam int DATA_W = MAX_FIELD_BITS + CW + 1;

    lbp_q_stat_t               q_stat;
    logic                      q_push, q_pop;
    logic [MAX_FIELD_BITS-1:0] f_value, b_value;
    logic [CW-1:0]             f_count, b_count;
    logic                      f_flush, b_flush;
    logic [DATA_W-1:0]         q_rd_data;

    // The front saturates the count and clears value bits beyond it, so the back
    // can merge the word with a plain shift and OR.
    lbp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .CW             (CW)
    ) u_front (
        .item    (item),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_value (f_value),
        .q_count (f_count),
        .q_flush (f_flush)
    );

    lbp_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({f_flush, f_count, f_value}),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    assign b_value = q_rd_data[MAX_FIELD_BITS-1:0];
    assign b_count = q_rd_data[MAX_FIELD_BITS +: CW];
    assign b_flush = q_rd_data[DATA_W-1];

    // The back keeps the stream position of its oldest unsent bit, so each byte's
    // running total is a single add.
    lbp_back #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .COUNT_BITS     (COUNT_BITS),
        .CW             (CW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .q_value (b_value),
        .q_count (b_count),
        .q_flush (b_flush),
        .stream  (stream)
    );

endmodule

`default_nettype wire

>>> rtl/core/lbp_checker.sv
// Port-level assertions for the bit packer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module lbp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [lbp_pkg::LBP_BYTE_W-1:0]      out_byte,
    input logic [lbp_pkg::LBP_VALID_W-1:0]     valid_bits,
    input logic                                last_of_run
);
    import lbp_pkg::*;

    // A word offered on the output stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn while stalled");

    a_vbits_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_bits != '0) && (valid_bits <= LBP_VALID_W'(LBP_BYTE_BITS)))
        else $error("valid_bits out of range");

    // A partial byte only comes from a flush, which always ends the item's run.
    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (valid_bits != LBP_VALID_W'(LBP_BYTE_BITS)) |-> last_of_run)
        else $error("partial byte not marked last of run");

    a_partial_pad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (valid_bits < LBP_VALID_W'(LBP_BYTE_BITS))
            |-> ((out_byte >> valid_bits) == '0))
        else $error("flushed byte has non-zero padding");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (stream.valid),
    .out_ready   (stream.ready),
    .out_byte    (stream.out_byte),
    .valid_bits  (stream.valid_bits),
    .last_of_run (stream.last_of_run)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the LSB-first variable-length bit packer.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    import lbp_pkg::*;

    // One word of the output stream as the checker expects it.
    typedef struct packed {
        logic [LBP_BYTE_W-1:0]  data;
        logic [LBP_VALID_W-1:0] nbits;
        logic                   last;
        logic [LBP_TOTAL_W-1:0] total;
    } stream_word_t;

    // One row of the directed table. Where typed is set, the row yields exactly one
    // stream word, and that word is written out here rather than predicted.
    typedef struct packed {
        logic [LBP_VALUE_W-1:0]     value;
        logic [LBP_BIT_LEN_W-1:0]   bit_len;
        logic                       flush;
        logic                       typed;
        stream_word_t               word;
    } packer_row_t;

    localparam int NUM_ROWS     = 18;
    localparam int NUM_RUSHED   = 20;
    localparam int NUM_SHUFFLED = 142;
    localparam int NUM_CALM     = 40;
    localparam int CHOKE_CYCLES = 150;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    lbp_in_if  item_ch ();
    lbp_out_if stream_ch ();

    lsb_first_bit_packer #(
        .MAX_FIELD_BITS (LBP_MAX_FIELD_BITS),
        .COUNT_BITS     (LBP_COUNT_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .stream (stream_ch)
    );

    // Predictor state: the partial byte (up to eight bits while a byte is being
    // completed), how many of its bits are filled, and the running bit count.
    logic [LBP_BYTE_BITS-1:0] acc_bits;
    logic [3:0]               acc_count;
    logic [LBP_TOTAL_W-1:0]   bit_total;

    // Words that one accepted item should produce, and the words still owed by the block.
    stream_word_t item_bytes[$];
    stream_word_t expected_bytes[$];

    packer_row_t packer_rows[0:NUM_ROWS-1];

    int  error_count = 0;
    // Set while the sender must offer items back to back.
    bit  rush = 1'b0;
    // Asks the receiver to hold off for a long stretch; the receiver clears it.
    bit  choke_req = 1'b0;
    // Final part of the run: no idling on either side.
    bit  calm = 1'b0;

    always #1 clk = ~clk;

    // Works out the words that one accepted item yields, and advances the predictor.
    // Counts above the field limit saturate, bits above the count are ignored, and a
    // flush emits the partial byte zero-padded only when some bits are pending.
    function automatic void pack_item(input logic [LBP_VALUE_W-1:0] value,
                                      input logic [LBP_BIT_LEN_W-1:0] bit_len,
                                      input logic flush);
        int           n_bits;
        int           i;
        stream_word_t w;
        item_bytes.delete();
        n_bits = (bit_len > LBP_MAX_FIELD_BITS) ? LBP_MAX_FIELD_BITS : int'(bit_len);
        for (i = 0; i < n_bits; i++)
        begin
            acc_bits[acc_count[2:0]] = value[i];
            acc_count = acc_count + 4'd1;
            bit_total = bit_total + 1'b1;
            if (acc_count == LBP_BYTE_BITS)
            begin
                w = '{data: acc_bits, nbits: 4'd8, last: 1'b0, total: bit_total};
                item_bytes.push_back(w);
                acc_bits  = '0;
                acc_count = '0;
            end
        end
        if (flush && acc_count != 0)
        begin
            w = '{data: acc_bits, nbits: acc_count, last: 1'b0, total: bit_total};
            item_bytes.push_back(w);
            acc_bits  = '0;
            acc_count = '0;
        end
        if (item_bytes.size() > 0)
        begin
            w = item_bytes.pop_back();
            w.last = 1'b1;
            item_bytes.push_back(w);
        end
    endfunction

    // Offers one item, waits for the handshake and records what it should yield.
    // Called at a rising edge; returns at the edge at which the item was taken, with
    // valid still high so that the next call either keeps it up or drops it once.
    task automatic offer_item(input logic [LBP_VALUE_W-1:0] value,
                              input logic [LBP_BIT_LEN_W-1:0] bit_len,
                              input logic flush,
                              input logic typed,
                              input stream_word_t word);
        int gap;
        gap = 0;
        if (!calm && !rush && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.value     <= value;
        item_ch.bit_len   <= bit_len;
        item_ch.flush     <= flush;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pack_item(value, bit_len, flush);
        if (typed)
            expected_bytes.push_back(word);
        else
            foreach (item_bytes[k])
                expected_bytes.push_back(item_bytes[k]);
    endtask

    // A random item: mostly full-range values and counts within the field limit, with
    // some saturating counts, short counts and all-zero or all-one values mixed in.
    task automatic offer_random_item();
        logic [LBP_VALUE_W-1:0]     value;
        logic [LBP_BIT_LEN_W-1:0]   bit_len;
        logic                       flush;
        int                         pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            value = '1;
        else if (pick == 1)
            value = '0;
        else
            value = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 6)
            bit_len = LBP_BIT_LEN_W'($urandom_range(0, 64));
        else if (pick < 8)
            bit_len = LBP_BIT_LEN_W'($urandom_range(0, 9));
        else
            bit_len = LBP_BIT_LEN_W'($urandom_range(65, 127));
        flush = ($urandom_range(0, 3) == 0);
        offer_item(value, bit_len, flush, 1'b0, '0);
    endtask

    // Directed table. Starting from reset it walks through a full byte, a flush with
    // nothing pending, a zero-padded flush, counts above the limit, all-zero and all-one
    // values, a flush after a zero count, and an item that yields the most words.
    initial
    begin
        packer_rows[0]  = '{64'h0000_0000_0000_00A5, 7'd8,   1'b0, 1'b1,
                            '{8'hA5, 4'd8, 1'b1, 32'd8}};
        packer_rows[1]  = '{64'h0,                   7'd0,   1'b1, 1'b0, '0};
        packer_rows[2]  = '{64'hFFFF_FFFF_FFFF_FFFF, 7'd3,   1'b1, 1'b1,
                            '{8'h07, 4'd3, 1'b1, 32'd11}};
        packer_rows[3]  = '{64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 1'b0, 1'b0, '0};
        packer_rows[4]  = '{64'h0,                   7'd64,  1'b0, 1'b0, '0};
        packer_rows[5]  = '{64'h8000_0000_0000_0001, 7'd64,  1'b1, 1'b0, '0};
        packer_rows[6]  = '{64'h5,                   7'd3,   1'b0, 1'b0, '0};
        packer_rows[7]  = '{64'h0,                   7'd0,   1'b1, 1'b1,
                            '{8'h05, 4'd3, 1'b1, 32'd206}};
        packer_rows[8]  = '{64'h1,                   7'd1,   1'b0, 1'b0, '0};
        packer_rows[9]  = '{64'hFFFF_FFFF_FFFF_FFFF, 7'd64,  1'b1, 1'b0, '0};
        packer_rows[10] = '{64'hDEAD_BEEF_0123_4567, 7'd65,  1'b1, 1'b0, '0};
        packer_rows[11] = '{64'h1,                   7'd7,   1'b0, 1'b0, '0};
        packer_rows[12] = '{64'h1,                   7'd1,   1'b0, 1'b0, '0};
        packer_rows[13] = '{64'hFFFF_FFFF_FFFF_FFFE, 7'd64,  1'b0, 1'b0, '0};
        packer_rows[14] = '{64'h7FFF_FFFF_FFFF_FFFF, 7'd63,  1'b1, 1'b0, '0};
        packer_rows[15] = '{64'h3,                   7'd2,   1'b1, 1'b0, '0};
        packer_rows[16] = '{64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   1'b0, 1'b0, '0};
        packer_rows[17] = '{64'h0,                   7'd64,  1'b1, 1'b0, '0};
    end

    // Stimulus: reset, the directed table, a back-to-back burst against a stalled
    // receiver, random items with idling, and a final calm stretch.
    initial
    begin
        acc_bits  = '0;
        acc_count = '0;
        bit_total = '0;
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.value     <= '0;
        item_ch.bit_len   <= '0;
        item_ch.flush     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            offer_item(packer_rows[r].value, packer_rows[r].bit_len,
                       packer_rows[r].flush, packer_rows[r].typed, packer_rows[r].word);

        // The receiver stops taking words while the sender keeps offering random items,
        // so the queue and the output register fill and the input is held off.
        rush      = 1'b1;
        choke_req = 1'b1;
        repeat (NUM_RUSHED) offer_random_item();
        rush = 1'b0;

        repeat (NUM_SHUFFLED) offer_random_item();

        calm = 1'b1;
        repeat (NUM_CALM) offer_random_item();
        item_ch.valid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[lsb_first_bit_packer] OK");
        else
            $display("[lsb_first_bit_packer] ERROR");
        $finish;
    end

    // Receiver: stalls in random bursts, holds off for a long stretch once when asked,
    // and takes every word once the run has gone calm.
    initial
    begin
        stream_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (calm)
            begin
                stream_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if (choke_req)
            begin
                stream_ch.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge clk);
                choke_req = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stream_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                stream_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Checker: every word taken from the stream is compared with the oldest one owed.
    always @(posedge clk)
    begin : check_stream
        stream_word_t want;
        if (rst_n && stream_ch.valid && stream_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected stream word: out_byte %0h valid_bits %0d total_bits %0d",
                       stream_ch.out_byte, stream_ch.valid_bits, stream_ch.total_bits);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (stream_ch.out_byte !== want.data)
                begin
                    $error("out_byte: expected %0h, got %0h", want.data, stream_ch.out_byte);
                    error_count++;
                end
                if (stream_ch.valid_bits !== want.nbits)
                begin
                    $error("valid_bits: expected %0d, got %0d",
                           want.nbits, stream_ch.valid_bits);
                    error_count++;
                end
                if (stream_ch.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last, stream_ch.last_of_run);
                    error_count++;
                end
                if (stream_ch.total_bits !== want.total)
                begin
                    $error("total_bits: expected %0d, got %0d",
                           want.total, stream_ch.total_bits);
                    error_count++;
                end
            end
        end
    end

    // Watchdog, several times the slowest correct run.
    initial
    begin
        #400000;
        $display("[lsb_first_bit_packer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
